/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the motion activity detector RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mad_pkg.sv */
// Shared constants for the motion activity detector.
// No dependencies; imported by every module of the block.
package mad_pkg;

    localparam int AXIS_W          = 16;
    localparam int MAG_W           = 16;
    localparam int SQ_W            = 2 * MAG_W;
    localparam int THR_W           = 16;
    localparam int DEFAULT_WINDOW  = 100;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1147;  // 0.07 g

endpackage

/* hw/rtl/mad_sqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on mad_pkg.
module mad_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mad_pkg::SQ_W-1:0]  radicand,
    output logic                      done,
    output logic [mad_pkg::MAG_W-1:0] root
);
    import mad_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic [SQ_W-1:0]    rad_reg;
    logic [MAG_W+1:0]   rem_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [MAG_W+1:0]   rem_sh;
    logic [MAG_W+1:0]   trial;
    logic               take;

    // rem stays below 2^MAG_W before the last step, so the top bits drop safely
    assign rem_sh = {rem_reg[MAG_W-1:0], rad_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[MAG_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hw/rtl/mad_divider.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on mad_pkg for style only; widths come from parameters.
module mad_divider
#(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    import mad_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    // rem_reg < den_reg always, so it fits DEN_W bits
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in at the bottom of num_reg
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* hw/rtl/mad_ring.sv */
// Change ring storage: single-port synchronous RAM, registered read.
// Depends on mad_pkg for the entry width.
module mad_ring
#(
    parameter int DEPTH  = 100,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         addr,
    input  logic [mad_pkg::MAG_W-1:0] wr_data,
    output logic [mad_pkg::MAG_W-1:0] rd_data
);
    import mad_pkg::*;

    logic [MAG_W-1:0] mem [DEPTH];
    logic [MAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/motion_activity_detector.sv */
// Motion activity detector top level: sequencer, ring update, threshold test.
// Depends on mad_pkg, mad_sqrt, mad_divider, mad_ring, assert_macros.svh.

// Takes one x/y/z accelerometer word (1/16384 g per LSB) at a time and returns one
// word holding the floor magnitude, the floored mean of the last WINDOW magnitude
// changes and a moving flag (sum of changes > threshold * count). Each sample goes
// through squaring of the three axes, 16 square root steps, the ring update and
// SUM_W serial divide steps, SUM_W = 16 + clog2(WINDOW+1) (23 at WINDOW = 100). The
// next sample is accepted only once the result word has been emitted. The first
// sample after reset skips the ring update and the divide. A new sample is taken
// while the previous result still waits on the output. The change ring lives in a
// single-port RAM and needs no clearing after reset. The threshold may be written
// at any time the block is idle; cfg_ready is always high.
`include "assert_macros.svh"

module motion_activity_detector
#(
    parameter int WINDOW = mad_pkg::DEFAULT_WINDOW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // s_axis_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [47:0]               s_axis_tdata,
    // m_axis_tdata: magnitude [15:0], mean_change [31:16], moving [32], zero [39:33]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [39:0]               m_axis_tdata,
    // cfg_data: motion_threshold
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mad_pkg::THR_W-1:0] cfg_data
);
    import mad_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int SUM_W  = MAG_W + FILL_W;
    localparam int PROD_W = THR_W + FILL_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SQUARE   = 4'd1;
    localparam logic [3:0] ST_ROOT_GO  = 4'd2;
    localparam logic [3:0] ST_ROOT     = 4'd3;
    localparam logic [3:0] ST_UPDATE   = 4'd4;
    localparam logic [3:0] ST_DIV_GO   = 4'd5;
    localparam logic [3:0] ST_DIV      = 4'd6;
    localparam logic [3:0] ST_EMIT     = 4'd7;

    logic [3:0]              state_reg;
    logic [1:0]              sq_cnt_reg;
    logic [THR_W-1:0]        thr_reg;

    logic signed [AXIS_W-1:0] ax_reg [3];
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         acc_reg;

    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        last_reg;
    logic [MAG_W-1:0]        diff_reg;
    logic                    have_prev_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [MAG_W-1:0]        mean_reg;

    logic                    out_valid_reg;
    logic [MAG_W-1:0]        out_mag_reg;
    logic [MAG_W-1:0]        out_mean_reg;
    logic                    out_moving_reg;

    logic signed [AXIS_W-1:0]   ax_sel;
    logic signed [2*AXIS_W-1:0] ax_sq;
    logic                    root_done;
    logic [MAG_W-1:0]        root;
    logic                    div_done;
    logic [SUM_W-1:0]        quotient;
    logic [MAG_W-1:0]        rd_data;
    logic                    ring_full;
    logic [MAG_W-1:0]        old_change;
    logic [SUM_W-1:0]        sum_next;
    logic                    emit_ok;
    logic                    fill_nz;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    assign ax_sel     = ax_reg[sq_cnt_reg];
    assign ax_sq      = ax_sel * ax_sel;
    assign ring_full  = (fill_reg == FILL_W'(WINDOW));
    assign old_change = ring_full ? rd_data : '0;
    assign sum_next   = sum_reg - SUM_W'(old_change) + SUM_W'(diff_reg);
    assign emit_ok    = !out_valid_reg || m_axis_tready;
    assign fill_nz    = (fill_reg != '0);

    mad_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ROOT_GO),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root)
    );

    mad_divider #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_GO),
        .numer    (sum_reg),
        .denom    (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // oldest change is read as the root finishes, used in the update cycle
    mad_ring #(.DEPTH(WINDOW), .ADDR_W(PTR_W)) u_ring
    (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPDATE),
        .rd_en   ((state_reg == ST_ROOT) && root_done),
        .addr    (ptr_reg),
        .wr_data (diff_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sq_cnt_reg     <= '0;
            thr_reg        <= THRESHOLD_RESET;
            last_reg       <= '0;
            have_prev_reg  <= 1'b0;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_ROOT_GO;
                    end
                end
                ST_ROOT_GO:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        last_reg      <= root;
                        have_prev_reg <= 1'b1;
                        state_reg     <= have_prev_reg ? ST_UPDATE : ST_EMIT;
                    end
                end
                ST_UPDATE:
                begin
                    sum_reg   <= sum_next;
                    ptr_reg   <= (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                    if (!ring_full)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ax_reg[0] <= s_axis_tdata[15:0];
            ax_reg[1] <= s_axis_tdata[31:16];
            ax_reg[2] <= s_axis_tdata[47:32];
            acc_reg   <= '0;
        end
        if (state_reg == ST_SQUARE)
        begin
            // square one axis per cycle, accumulate each square in the cycle after
            if (sq_cnt_reg != 2'd3)
            begin
                sq_reg <= SQ_W'(unsigned'(ax_sq));
            end
            if (sq_cnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg + sq_reg;
            end
        end
        if ((state_reg == ST_ROOT) && root_done)
        begin
            mag_reg  <= root;
            diff_reg <= (root >= last_reg) ? (root - last_reg) : (last_reg - root);
        end
        if (state_reg == ST_DIV_GO)
        begin
            prod_reg <= PROD_W'(thr_reg) * PROD_W'(fill_reg);
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            mean_reg <= quotient[MAG_W-1:0];
        end
        if ((state_reg == ST_EMIT) && emit_ok)
        begin
            out_mag_reg    <= mag_reg;
            out_mean_reg   <= fill_nz ? mean_reg : '0;
            out_moving_reg <= fill_nz && (PROD_W'(sum_reg) > prod_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_moving_reg, out_mean_reg, out_mag_reg};

    `MAD_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= FILL_W'(WINDOW), "ring fill above window")
    `MAD_ASSERT_NOW(a_ptr_range, 1'b1, ptr_reg <= PTR_W'(WINDOW - 1), "ring pointer out of range")
    `MAD_ASSERT_NOW(a_evict_fits, (state_reg == ST_UPDATE) && ring_full,
        SUM_W'(rd_data) <= sum_reg, "evicted change exceeds running sum")
    `MAD_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV_GO, fill_nz, "divide by empty ring")
    `MAD_ASSERT_NEXT(a_first_no_update, (state_reg == ST_ROOT) && root_done && !have_prev_reg,
        state_reg == ST_EMIT && fill_reg == '0, "first sample touched the ring")

endmodule

/* tb/sv/activity_checker.sv */
// Scoreboard for motion_activity_detector: tracks the threshold writes, predicts one
// result word per accepted sample and compares it with the word leaving the block.
// Depends on mad_pkg only.
`timescale 1ns / 100ps

module activity_checker
#(
    parameter int WINDOW = mad_pkg::DEFAULT_WINDOW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // s_axis_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [47:0]               s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // m_axis_tdata: magnitude [15:0], mean_change [31:16], moving [32], zero [39:33]
    input  logic [39:0]               m_axis_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [mad_pkg::THR_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        pending,
    output int                        words_checked,
    output int                        moving_words
);

    import mad_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] mean_change;
        logic             moving;
    } activity_t;

    activity_t        expected_words[$];

    logic [THR_W-1:0] threshold;
    logic [MAG_W-1:0] last_mag;
    logic             have_last;
    logic [MAG_W-1:0] change_hist[WINDOW];
    int unsigned      hist_ptr;
    int unsigned      hist_fill;
    int unsigned      change_total;

    function automatic logic [MAG_W-1:0] floor_root(input logic [33:0] n);
        logic [33:0] rem;
        logic [33:0] root;
        logic [33:0] probe;
        rem   = n;
        root  = '0;
        probe = 34'h1 << 32;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root[MAG_W-1:0];
    endfunction

    // Updates the change history with one sample and returns the word it should produce.
    function automatic activity_t advance_activity(input logic [47:0] word);
        longint           ax;
        longint           ay;
        longint           az;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] diff;
        activity_t        res;
        ax  = longint'($signed(word[15:0]));
        ay  = longint'($signed(word[31:16]));
        az  = longint'($signed(word[47:32]));
        mag = floor_root(34'(ax * ax + ay * ay + az * az));
        res = '0;
        if (have_last)
        begin
            diff = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
            // full window: oldest change drops out before the slot is reused
            if (hist_fill >= WINDOW)
                change_total -= change_hist[hist_ptr];
            else
                hist_fill++;
            change_hist[hist_ptr] = diff;
            change_total += diff;
            hist_ptr = (hist_ptr == WINDOW - 1) ? 0 : hist_ptr + 1;
        end
        last_mag  = mag;
        have_last = 1'b1;
        res.magnitude = mag;
        if (hist_fill != 0)
        begin
            res.mean_change = MAG_W'(change_total / hist_fill);
            res.moving      = longint'(change_total) > longint'(threshold) * hist_fill;
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatches < 10)
            $display("[%0t] activity_checker: %s", $time, msg);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        activity_t want;
        if (!rst_n)
        begin
            threshold     = THRESHOLD_RESET;
            last_mag      = '0;
            have_last     = 1'b0;
            hist_ptr      = 0;
            hist_fill     = 0;
            change_total  = 0;
            mismatches    = 0;
            words_checked = 0;
            moving_words  = 0;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(advance_activity(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                    note_failure($sformatf("result word %h with nothing expected",
                                           m_axis_tdata));
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (m_axis_tdata[32] === 1'b1)
                        moving_words++;
                    if (m_axis_tdata[15:0] !== want.magnitude ||
                        m_axis_tdata[31:16] !== want.mean_change ||
                        m_axis_tdata[32] !== want.moving ||
                        m_axis_tdata[39:33] !== 7'd0)
                        note_failure($sformatf(
                            "word %0d: want mag %0d mean %0d moving %0b, got mag %0d mean %0d moving %0b pad %h",
                            words_checked, want.magnitude, want.mean_change, want.moving,
                            m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[32],
                            m_axis_tdata[39:33]));
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

/* tb/sv/motion_activity_detector_tb.sv */
// Top of the motion_activity_detector testbench: clock, reset, sample and threshold
// stimulus, output back-pressure and the verdict. Needs mad_pkg, DUT, activity_checker.
`timescale 1ns / 100ps

module motion_activity_detector_tb;

    import mad_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum int {MOTION_STILL, MOTION_DRIFT, MOTION_SHAKE, MOTION_WILD} motion_mode_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [39:0]      m_axis_tdata;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data      = '0;

    int mismatches;
    int pending;
    int words_checked;
    int moving_words;
    int samples_sent;
    int settings_used;
    int cycle_count;

    int rx_mode;
    int rx_mode_left;
    int rx_stall_left;
    bit rx_ready;

    motion_activity_detector dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    activity_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked),
        .moving_words  (moving_words)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
            $display("motion_activity_detector_tb NOT OK");
            $finish;
        end
    end

    // Output back-pressure: rotates between always ready, coin-flip and long stalls.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(64, 512);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0: rx_ready = 1'b1;
            1: rx_ready = $urandom_range(0, 1);
            default:
            begin
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    rx_ready = 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    rx_stall_left = $urandom_range(1, 20);
                    rx_ready      = 1'b0;
                end
                else
                    rx_ready = 1'b1;
            end
        endcase
        m_axis_tready <= rst_n && rx_ready;
    end

    function automatic logic [47:0] pack_sample(input int ax, input int ay, input int az);
        return {16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic logic [47:0] make_sample(input motion_mode_t mode);
        int ax;
        int ay;
        int az;
        case (mode)
            MOTION_STILL:
            begin
                ax = int'($urandom_range(0, 128)) - 64;
                ay = int'($urandom_range(0, 128)) - 64;
                az = 16384 + int'($urandom_range(0, 128)) - 64;
            end
            MOTION_DRIFT:
            begin
                ax = int'($urandom_range(0, 4096)) - 2048;
                ay = int'($urandom_range(0, 4096)) - 2048;
                az = 16384 + int'($urandom_range(0, 4096)) - 2048;
            end
            MOTION_SHAKE:
            begin
                ax = int'($urandom_range(0, 32768)) - 16384;
                ay = int'($urandom_range(0, 32768)) - 16384;
                az = int'($urandom_range(0, 32768)) - 16384;
            end
            default:
            begin
                ax = $urandom_range(0, 65535);
                ay = $urandom_range(0, 65535);
                az = $urandom_range(0, 65535);
            end
        endcase
        return pack_sample(ax, ay, az);
    endfunction

    // Leaves valid high on return; the caller lowers it when a gap follows.
    task automatic push_sample(input logic [47:0] word);
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Threshold changes only with nothing in flight.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count, input bit steady);
        int           sent_here;
        int           burst;
        int           gap;
        int           pick;
        motion_mode_t mode;
        sent_here = 0;
        while (sent_here < count)
        begin
            burst = $urandom_range(1, 16);
            pick  = $urandom_range(0, 99);
            mode  = (pick < 30) ? MOTION_STILL :
                    (pick < 60) ? MOTION_DRIFT :
                    (pick < 85) ? MOTION_SHAKE : MOTION_WILD;
            for (int i = 0; i < burst && sent_here < count; i++)
            begin
                push_sample(make_sample(mode));
                sent_here++;
            end
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [47:0]      directed[$];
        logic [THR_W-1:0] phase_thr[PHASES];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first word after reset has no change history; then axis extremes and big jumps
        directed = '{pack_sample(0, 0, 0),
                     pack_sample(32767, 32767, 32767),
                     pack_sample(-32768, -32768, -32768),
                     pack_sample(0, 0, 0),
                     pack_sample(-32768, 0, 0),
                     pack_sample(32767, 0, 0),
                     pack_sample(0, -32768, 0),
                     pack_sample(0, 32767, 0),
                     pack_sample(0, 0, -32768),
                     pack_sample(0, 0, 32767),
                     pack_sample(1, 0, 0),
                     pack_sample(-1, -1, -1),
                     pack_sample(0, 0, 16384),
                     pack_sample(0, 0, 16384),
                     pack_sample(0, 0, 16385),
                     pack_sample(16384, 0, 0),
                     pack_sample(-32768, 32767, -32768),
                     pack_sample(32767, -32768, 32767),
                     pack_sample(0, 0, 0),
                     pack_sample(0, 0, 1147),
                     pack_sample(0, 0, 0)};
        foreach (directed[i])
            push_sample(directed[i]);
        s_axis_tvalid <= 1'b0;

        phase_thr[0] = '0;
        phase_thr[1] = '1;
        phase_thr[2] = 16'(THR_W'($urandom_range(0, 2000)));
        phase_thr[3] = 16'd1;
        phase_thr[4] = 16'($urandom_range(0, 65535));
        phase_thr[5] = THRESHOLD_RESET;
        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(phase_thr[p]);
            run_random(RANDOM_ITEMS / PHASES, p % 3 == 1);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d samples under %0d threshold settings after the reset value",
                 samples_sent, settings_used);
        $display("checked %0d result words, %0d of them flagged moving",
                 words_checked, moving_words);
        if (mismatches == 0 && pending == 0)
            $display("motion_activity_detector_tb OK");
        else
            $display("motion_activity_detector_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mad_pkg.sv
hw/rtl/mad_sqrt.sv
hw/rtl/mad_divider.sv
hw/rtl/mad_ring.sv
hw/rtl/motion_activity_detector.sv
tb/sv/activity_checker.sv
tb/sv/motion_activity_detector_tb.sv
